FILE: sv/lru_page_replacement_top_macros.svh
// assertion macros shared by the lru page replacement checker
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LRU_PR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define LRU_PR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lru_pr_pkg.sv
// shared constants and types for the lru page replacement block
package lru_pr_pkg;

  // default sizes of the frame set
  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned IDX_OUT_W   = 3;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned OUT_BITS    = IDX_OUT_W + 1 + PAGE_W + TOTAL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  // reset value of the frame count register
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  // saturation point of the fault counter
  localparam logic [TOTAL_W-1:0] FAULT_MAX = '1;

  // outcome of one lookup
  typedef struct packed {
    logic hit;
    logic fill;
    logic victim_valid;
  } lru_pr_pick_t;

endpackage

FILE: sv/lru_pr_pick.sv
// lookup and replacement choice: tag compare, fill slot and lru victim
module lru_pr_pick #(
  parameter int unsigned FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
  parameter int unsigned AW        = 3,
  parameter int unsigned CW        = 4
) (
  input  logic [PAGE_BITS-1:0]      page_i,
  input  logic [PAGE_BITS-1:0]      frame_page_i [FRAMES],
  input  logic [FRAMES-1:0]         frame_valid_i,
  input  logic [AW-1:0]             age_i [FRAMES],
  input  logic [FRAMES-1:0]         managed_i,
  input  logic [CW-1:0]             fill_i,
  input  logic [CW-1:0]             n_i,
  output lru_pr_pkg::lru_pr_pick_t  pick_o,
  output logic [FRAMES-1:0]         slot_oh_o
);
  import lru_pr_pkg::*;

  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] hit_oh;
  logic [FRAMES-1:0] cand;
  logic [FRAMES-1:0] fill_oh;
  logic [FRAMES-1:0] vic_oh;
  logic              any_hit;
  logic              has_empty;

  // compare against every managed frame, and mark the fill slot
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      cand[j]    = managed_i[j] && frame_valid_i[j];
      match[j]   = cand[j] && (frame_page_i[j] == page_i);
      fill_oh[j] = (CW'(j) == fill_i);
    end
  end

  // lowest matching frame wins
  assign hit_oh    = match & (~match + FRAMES'(1));
  assign any_hit   = |match;
  assign has_empty = (fill_i < n_i);

  // oldest frame, lowest index on a tie
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      vic_oh[j] = cand[j];
      for (int k = 0; k < FRAMES; k++) begin
        if (k < j && cand[k] && age_i[k] >= age_i[j]) begin
          vic_oh[j] = 1'b0;
        end
        if (k > j && cand[k] && age_i[k] > age_i[j]) begin
          vic_oh[j] = 1'b0;
        end
      end
    end
  end

  // pick the slot for this reference
  always_comb begin
    pick_o.hit          = any_hit;
    pick_o.fill         = !any_hit && has_empty;
    pick_o.victim_valid = !any_hit && !has_empty && (|cand);
    if (any_hit) begin
      slot_oh_o = hit_oh;
    end else if (has_empty) begin
      slot_oh_o = fill_oh;
    end else begin
      slot_oh_o = vic_oh;
    end
  end

endmodule

FILE: sv/lru_page_replacement_top.sv
// LRU page replacement over a fully associative frame set. One page reference
// is taken per clock while the result side is not stalled; it is held in an input
// register, then the tag compare over all frames, the victim choice and the age
// update finish and load the result register and the replacement state, so a new
// reference can follow in every cycle unless the result side stalls. This rate
// rests on the parallel compare and age update across the frames. The frame
// count register (0 reads as 1, values above FRAMES as FRAMES) may be written
// only while no reference is in flight. All tables are ready right after reset.
module lru_page_replacement_top #(
  parameter int unsigned FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lru_pr_pkg::CFG_W-1:0]       cfg_wdata_i,     // frames_in_use
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [lru_pr_pkg::PAGE_W-1:0]      s_axis_tdata_i,  // page_number
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // frame_index, victim_valid, victim_page, fault_total, zero pad
  output logic [lru_pr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                               m_axis_tuser_o   // hit
);
  import lru_pr_pkg::*;

  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam logic [AW-1:0] AGE_MAX = AW'(FRAMES - 1);

  logic [CFG_W-1:0]     frames_in_use_q;
  logic                 in_valid_q;
  logic [PAGE_BITS-1:0] in_page_q;
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    frame_valid_q, frame_valid_d;
  logic [AW-1:0]        age_q [FRAMES];
  logic [AW-1:0]        age_d [FRAMES];
  logic [CW-1:0]        fill_q, fill_d;
  logic [TOTAL_W-1:0]   fault_q, fault_d;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  logic                 out_vv_q;
  logic [PAGE_W-1:0]    out_vpage_q;
  logic [TOTAL_W-1:0]   out_total_q;

  logic                 advance;
  logic [CW-1:0]        n;
  logic [FRAMES-1:0]    managed;
  lru_pr_pick_t         pick;
  logic [FRAMES-1:0]    slot_oh;
  logic [AW-1:0]        slot;
  logic [AW-1:0]        slot_age;
  logic [PAGE_BITS-1:0] slot_page;

  // handshake: the input stage moves when the result register is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // effective frame count and managed mask
  always_comb begin
    if (frames_in_use_q == '0) begin
      n = CW'(1);
    end else if (32'(frames_in_use_q) > FRAMES) begin
      n = CW'(FRAMES);
    end else begin
      n = CW'(frames_in_use_q);
    end
    for (int j = 0; j < FRAMES; j++) begin
      managed[j] = (CW'(j) < n);
    end
  end

  lru_pr_pick #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_pick (
    .page_i        (in_page_q),
    .frame_page_i  (frame_page_q),
    .frame_valid_i (frame_valid_q),
    .age_i         (age_q),
    .managed_i     (managed),
    .fill_i        (fill_q),
    .n_i           (n),
    .pick_o        (pick),
    .slot_oh_o     (slot_oh)
  );

  // one-hot slot to index, age and resident page
  always_comb begin
    slot      = '0;
    slot_age  = '0;
    slot_page = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (slot_oh[j]) begin
        slot      = slot | AW'(j);
        slot_age  = slot_age | age_q[j];
        slot_page = slot_page | frame_page_q[j];
      end
    end
  end

  // next ages, valid bits, fill pointer and fault count
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      age_d[j]         = age_q[j];
      frame_valid_d[j] = frame_valid_q[j] || slot_oh[j];
      if (slot_oh[j]) begin
        age_d[j] = '0;
      end else if (managed[j] && frame_valid_q[j] && age_q[j] != AGE_MAX &&
                   (!pick.hit || age_q[j] < slot_age)) begin
        age_d[j] = age_q[j] + AW'(1);
      end
    end
    fill_d  = pick.fill ? fill_q + CW'(1) : fill_q;
    fault_d = (!pick.hit && fault_q != FAULT_MAX) ? fault_q + TOTAL_W'(1) : fault_q;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_page_q <= PAGE_BITS'(s_axis_tdata_i);
    end
  end

  // replacement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      fill_q        <= '0;
      fault_q       <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        age_q[j] <= '0;
      end
    end else if (advance) begin
      frame_valid_q <= frame_valid_d;
      fill_q        <= fill_d;
      fault_q       <= fault_d;
      for (int j = 0; j < FRAMES; j++) begin
        age_q[j] <= age_d[j];
      end
    end
  end

  // resident pages, read only behind the valid bits
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < FRAMES; j++) begin
      if (advance && slot_oh[j]) begin
        frame_page_q[j] <= in_page_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q   <= pick.hit;
      out_idx_q   <= IDX_OUT_W'(slot);
      out_vv_q    <= pick.victim_valid;
      out_vpage_q <= pick.victim_valid ? PAGE_W'(slot_page) : '0;
      out_total_q <= fault_d;
    end
  end

  // output word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_hit_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_total_q, out_vpage_q, out_vv_q, out_idx_q};

endmodule

FILE: sv/lru_pr_chk.sv
// port-level checker for the lru page replacement block, with its bind
`include "lru_page_replacement_top_macros.svh"

module lru_pr_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [lru_pr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                               m_axis_tuser_o
);
  import lru_pr_pkg::*;

  localparam int unsigned VV_BIT = IDX_OUT_W;
  localparam int unsigned VP_LO  = IDX_OUT_W + 1;
  localparam int unsigned TOT_LO = VP_LO + PAGE_W;

  logic               out_acc;
  logic               vv;
  logic [PAGE_W-1:0]  vpage;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] last_total_q;
  logic [TOTAL_W-1:0] want_total;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign vv      = m_axis_tdata_o[VV_BIT];
  assign vpage   = m_axis_tdata_o[VP_LO +: PAGE_W];
  assign total   = m_axis_tdata_o[TOT_LO +: TOTAL_W];

  // expected fault count of the next word
  assign want_total = (m_axis_tuser_o || last_total_q == FAULT_MAX) ?
                      last_total_q : last_total_q + TOTAL_W'(1);

  // fault count of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_acc) begin
      last_total_q <= total;
    end
  end

  `LRU_PR_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result word changed while stalled")
  `LRU_PR_ASSERT_IMP(a_victim_zero, m_axis_tvalid_o && !vv, vpage == '0, "victim page not zero without a victim")
  `LRU_PR_ASSERT_IMP(a_hit_no_victim, m_axis_tvalid_o && m_axis_tuser_o, !vv, "victim reported on a hit")
  `LRU_PR_ASSERT_IMP(a_fault_count, out_acc, total == want_total, "fault count out of step with hits and faults")

endmodule

bind lru_page_replacement_top lru_pr_chk u_lru_pr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/tb_lru_page_replacement_top.sv
// self-checking testbench for the lru page replacement block with an in-bench lru predictor
module tb_lru_page_replacement_top;
  import lru_pr_pkg::*;

  localparam int unsigned FRAMES      = FRAMES_DEF;
  localparam int unsigned AGE_MAX     = FRAMES - 1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned PRINT_CAP   = 40;

  // one result word as seen on the master side
  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 victim_valid;
    logic [PAGE_W-1:0]    victim_page;
    logic [TOTAL_W-1:0]   fault_total;
  } page_result_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [PAGE_W-1:0]      s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  // predictor copy of the frame tables and the frame count register
  logic [PAGE_W-1:0]  lru_page  [FRAMES];
  logic               lru_valid [FRAMES];
  logic [2:0]         lru_age   [FRAMES];
  int unsigned        lru_fill;
  logic [TOTAL_W-1:0] lru_faults;
  logic [CFG_W-1:0]   lru_frames_cfg;

  page_result_t expected_lookups[$];
  page_result_t seen_result;
  page_result_t due_result;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit           stall_enable   = 1'b1;

  lru_page_replacement_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(posedge clk_i) begin
    if (stall_enable) begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_result.hit          = m_axis_tuser_o;
      seen_result.frame_index  = m_axis_tdata_o[2:0];
      seen_result.victim_valid = m_axis_tdata_o[3];
      seen_result.victim_page  = m_axis_tdata_o[19:4];
      seen_result.fault_total  = m_axis_tdata_o[35:20];
      if (expected_lookups.size() == 0) begin
        report_mismatch("result word with no lookup pending");
      end else begin
        due_result = expected_lookups.pop_front();
        if (seen_result.hit != due_result.hit)
          report_mismatch($sformatf("hit got %0d exp %0d", seen_result.hit, due_result.hit));
        if (seen_result.frame_index != due_result.frame_index)
          report_mismatch($sformatf("frame_index got %0d exp %0d",
                                    seen_result.frame_index, due_result.frame_index));
        if (seen_result.victim_valid != due_result.victim_valid)
          report_mismatch($sformatf("victim_valid got %0d exp %0d",
                                    seen_result.victim_valid, due_result.victim_valid));
        if (seen_result.victim_page != due_result.victim_page)
          report_mismatch($sformatf("victim_page got %h exp %h",
                                    seen_result.victim_page, due_result.victim_page));
        if (seen_result.fault_total != due_result.fault_total)
          report_mismatch($sformatf("fault_total got %0d exp %0d",
                                    seen_result.fault_total, due_result.fault_total));
      end
    end
  end

  // lru lookup on the predictor tables, updates them like the block does
  function automatic page_result_t lru_lookup(input logic [PAGE_W-1:0] page);
    int unsigned  n;
    int unsigned  slot;
    int unsigned  oldest;
    bit           found;
    bit           have;
    page_result_t r;
    n = lru_frames_cfg;
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    slot   = 0;
    oldest = 0;
    found  = 1'b0;
    have   = 1'b0;
    r      = '0;
    // parallel tag compare, first match wins
    for (int j = 0; j < n; j++) begin
      if (!found && lru_valid[j] && lru_page[j] == page) begin
        slot  = j;
        found = 1'b1;
      end
    end
    if (found) begin
      // refresh: only frames younger than the hit age up
      r.hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (j != slot && lru_valid[j] && lru_age[j] < lru_age[slot] && lru_age[j] < AGE_MAX)
          lru_age[j]++;
      end
      lru_age[slot] = '0;
    end else begin
      if (lru_faults != FAULT_MAX) lru_faults++;
      if (lru_fill < n) begin
        slot = lru_fill;
        lru_fill++;
      end else begin
        // oldest frame, lowest index on a tie
        for (int j = 0; j < n; j++) begin
          if (lru_valid[j] && (!have || lru_age[j] > oldest)) begin
            oldest = lru_age[j];
            slot   = j;
            have   = 1'b1;
          end
        end
        if (have) begin
          r.victim_valid = 1'b1;
          r.victim_page  = lru_page[slot];
        end
      end
      for (int j = 0; j < n; j++) begin
        if (j != slot && lru_valid[j] && lru_age[j] < AGE_MAX) lru_age[j]++;
      end
      lru_page[slot]  = page;
      lru_valid[slot] = 1'b1;
      lru_age[slot]   = '0;
    end
    r.frame_index = slot[IDX_OUT_W-1:0];
    r.fault_total = lru_faults;
    return r;
  endfunction

  // send one page word, random gaps ahead of it when idling is on
  task automatic send_page(input logic [PAGE_W-1:0] page);
    while (stall_enable && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= page;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_lookups = {expected_lookups, lru_lookup(page)};
  endtask

  // drop valid and let every pending result drain
  task automatic drain_lookups();
    s_axis_tvalid_i <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // frame count write, only with nothing in flight
  task automatic set_frames(input logic [CFG_W-1:0] count);
    drain_lookups();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lru_frames_cfg = count;
  endtask

  // fills, hits and lru evictions at the default count, then from small sets and an over-range count
  task automatic test_fill_and_evict();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    set_frames(4'd0);
    send_page(16'h0000);
    send_page(16'h5555);
    set_frames(4'd2);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h0001);
    set_frames(4'd15);
    send_page(16'h8000);
    send_page(16'h1234);
    send_page(16'hFEDC);
    send_page(16'h00FF);
    send_page(16'hFF00);
    send_page(16'h5555);
    send_page(16'h00FF);
    send_page(16'h4321);
  endtask

  // frames above a lowered count are ignored, then come back with stale ages
  task automatic test_frame_count_limits();
    set_frames(4'd3);
    send_page(16'hFF00);
    send_page(16'h8000);
    send_page(16'h7777);
    set_frames(4'd8);
    send_page(16'hFEDC);
    send_page(16'h1234);
    send_page(16'h0F0F);
    send_page(16'hF0F0);
  endtask

  // phases of working-set traffic with mixed hits and faults
  task automatic test_random_traffic();
    logic [PAGE_W-1:0] pool [10];
    logic [CFG_W-1:0]  count;
    int unsigned       span;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0:       count = 4'd1;
        1:       count = 4'd8;
        2:       count = 4'd0;
        3:       count = 4'd15;
        default: count = CFG_W'($urandom_range(0, 15));
      endcase
      set_frames(count);
      stall_enable = !(phase == 6 || phase == 7);
      foreach (pool[k]) pool[k] = PAGE_W'($urandom_range(0, 65535));
      span = (count > 8) ? 9 : count + 1;
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 99) < 75) send_page(pool[$urandom_range(0, span)]);
        else send_page(PAGE_W'($urandom_range(0, 65535)));
      end
    end
    stall_enable = 1'b1;
  endtask

  // single frame: a run of faults that each evict the one resident page, then a hit and one more fault
  task automatic test_single_frame_faults();
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] last_page;
    set_frames(4'd1);
    stall_enable = 1'b0;
    last_page = lru_page[0];
    for (int i = 0; i < 10; i++) begin
      page = PAGE_W'($urandom_range(0, 65535));
      if (page == last_page) page[0] = ~page[0];
      send_page(page);
      last_page = page;
    end
    stall_enable = 1'b1;
    send_page(last_page);
    send_page(~last_page);
  endtask

  // test sequence
  initial begin
    foreach (lru_valid[k]) begin
      lru_page[k]  = '0;
      lru_valid[k] = 1'b0;
      lru_age[k]   = '0;
    end
    lru_fill       = 0;
    lru_faults     = '0;
    lru_frames_cfg = CFG_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_evict();
    test_frame_count_limits();
    test_random_traffic();
    test_single_frame_faults();
    drain_lookups();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lru_pr_pkg.sv
sv/lru_pr_pick.sv
sv/lru_page_replacement_top.sv
sv/lru_pr_chk.sv
tb/tb_lru_page_replacement_top.sv
